[sv/rdc_pkg.sv]
package rdc_pkg;

  typedef enum logic [2:0] {
    PH_CLOSED     = 3'd0,
    PH_LISTEN     = 3'd1,
    PH_SYN_SENT   = 3'd2,
    PH_SYN_RCVD   = 3'd3,
    PH_OPEN       = 3'd4,
    PH_CLOSE_WAIT = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_CONNECT = 2'd1,
    OP_SEND    = 2'd2,
    OP_CLOSE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ENTRY  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CHK,
    ST_FLUSH_RD,
    ST_FLUSH_CHK,
    ST_EACK_RD,
    ST_EACK_CHK,
    ST_END
  } bstate_t;

  typedef struct packed {
    op_t         op;
    logic        syn;
    logic        ack;
    logic        eak;
    logic        rst;
    logic [15:0] seq;
    logic [15:0] ackno;
    logic        pay;
    logic        room;
  } event_t;

  typedef struct packed {
    kind_t       kind;
    logic        syn;
    logic        ack;
    logic        eak;
    logic        rst;
    logic [15:0] seq;
    logic [15:0] ackno;
  } item_t;

  typedef struct packed {
    item_t  item;
    logic   deliver;
    phase_t conn_state;
    logic   closed_now;
    logic   refused;
    logic   last;
  } result_t;

  localparam logic [15:0] PASSIVE_ISS  = 16'd200;
  localparam logic [15:0] ACTIVE_ISS   = 16'd100;
  localparam logic [3:0]  WINDOW_RESET = 4'd3;
  localparam logic        REG_WINDOW   = 1'b0;

  function automatic item_t mk_hdr(input logic syn, input logic ack, input logic eak,
                                   input logic rst, input logic [15:0] seq,
                                   input logic [15:0] ackno);
    item_t it;
    it.kind  = KIND_HEADER;
    it.syn   = syn;
    it.ack   = ack;
    it.eak   = eak;
    it.rst   = rst;
    it.seq   = seq;
    it.ackno = ackno;
    return it;
  endfunction

endpackage

[sv/rdc_ram.sv]
module rdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/rdc_front.sv]
module rdc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_tuser,
  input  logic [39:0]       in_tdata,
  output logic              q_valid,
  output rdc_pkg::event_t   q_ev,
  input  logic              q_pop
);
  import rdc_pkg::*;

  event_t     entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  event_t     ev;
  logic       push;

  // classify the raw transfer into an event record
  always_comb begin
    ev.op    = op_t'(in_tuser);
    ev.syn   = in_tdata[0];
    ev.ack   = in_tdata[1];
    ev.eak   = in_tdata[2];
    ev.rst   = in_tdata[3];
    ev.seq   = in_tdata[19:4];
    ev.ackno = in_tdata[35:20];
    ev.pay   = in_tdata[36];
    ev.room  = in_tdata[37];
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_ev      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= ev;
    end
  end

endmodule

[sv/rdc_back.sv]
module rdc_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        window,
  input  logic              q_valid,
  input  rdc_pkg::event_t   q_ev,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output rdc_pkg::result_t  res
);
  import rdc_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [7:0] DEPTH_W = 8'(TABLE_DEPTH);

  bstate_t                state_r, state_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [15:0]            sn_r, sn_nxt, su_r, su_nxt, si_r, si_nxt;
  logic [15:0]            rc_r, rc_nxt, ri_r, ri_nxt;
  logic [TABLE_DEPTH-1:0] occ_r, occ_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [IW-1:0]          slot_r, slot_nxt;
  logic                   found_r, found_nxt;
  logic [15:0]            v_r, v_nxt;
  item_t                  pend_r, pend_nxt;
  logic                   deliver_r, deliver_nxt, closed_r, closed_nxt;
  logic                   refused_r, refused_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                res_r, res_nxt;

  logic                   rd_en, wr_en;
  logic [15:0]            rd_data;
  logic [7:0]             span_w, n8;
  logic                   idx_in;
  logic [IW-1:0]          idx_a;
  logic                   out_free;
  logic                   push, push_last;

  rdc_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (v_r),
    .rd_en   (rd_en),
    .rd_addr (idx_a),
    .rd_data (rd_data)
  );

  assign span_w   = {3'b000, window, 1'b0};
  assign n8       = (span_w > DEPTH_W) ? DEPTH_W : span_w;
  assign idx_in   = (8'(idx_r) < n8);
  assign idx_a    = idx_r[IW-1:0];
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    item_t                   st_item;
    logic [15:0]             e_si, e_sn, e_su;
    phase_t                  ph;
    logic                    cl, dl, rf;
    logic                    in_win, hit, empty;
    logic signed [17:0]      rc_s, sq_s, ak_s, su_s, sn_s, w2_s;

    state_nxt   = state_r;
    phase_nxt   = phase_r;
    sn_nxt      = sn_r;
    su_nxt      = su_r;
    si_nxt      = si_r;
    rc_nxt      = rc_r;
    ri_nxt      = ri_r;
    occ_nxt     = occ_r;
    idx_nxt     = idx_r;
    slot_nxt    = slot_r;
    found_nxt   = found_r;
    v_nxt       = v_r;
    pend_nxt    = pend_r;
    deliver_nxt = deliver_r;
    closed_nxt  = closed_r;
    refused_nxt = refused_r;
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    push        = 1'b0;
    push_last   = 1'b0;

    st_item = '0;
    e_si = si_r;
    e_sn = sn_r;
    e_su = su_r;
    ph   = phase_r;
    cl   = 1'b0;
    dl   = 1'b0;
    rf   = 1'b0;
    rc_s = $signed({2'b00, rc_r});
    sq_s = $signed({2'b00, q_ev.seq});
    ak_s = $signed({2'b00, q_ev.ackno});
    su_s = $signed({2'b00, su_r});
    sn_s = $signed({2'b00, sn_r});
    w2_s = $signed({13'd0, window, 1'b0});
    in_win = (rc_s < sq_s) && (sq_s <= rc_s + w2_s);
    hit    = occ_r[idx_a] && (rd_data == v_r);
    empty  = !occ_r[idx_a];

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          pend_nxt = st_item;
          state_nxt = ST_END;
          unique case (q_ev.op)
            OP_SEGMENT: begin
              if (phase_r == PH_CLOSED) begin
                e_si = PASSIVE_ISS;
                e_sn = PASSIVE_ISS + 16'd1;
                e_su = PASSIVE_ISS;
                ph   = PH_LISTEN;
                sn_s = $signed({2'b00, e_sn});
              end
              if (q_ev.rst) begin
                cl = 1'b1;
              end else begin
                priority case (ph)
                  PH_LISTEN: begin
                    if (q_ev.ack) begin
                      pend_nxt = mk_hdr(1'b0, 1'b0, 1'b0, 1'b1, e_sn, rc_r);
                      cl = 1'b1;
                    end else if (q_ev.syn) begin
                      rc_nxt = q_ev.seq;
                      ri_nxt = q_ev.seq;
                      ph = PH_SYN_RCVD;
                      pend_nxt = mk_hdr(1'b1, 1'b1, 1'b0, 1'b0, e_si, q_ev.seq);
                    end else begin
                      cl = 1'b1;
                    end
                  end
                  PH_SYN_SENT: begin
                    if (q_ev.syn && q_ev.ack) begin
                      rc_nxt = q_ev.seq;
                      ri_nxt = q_ev.seq;
                      e_su = q_ev.ackno + 16'd1;
                      ph = PH_OPEN;
                      pend_nxt = mk_hdr(1'b0, 1'b1, 1'b0, 1'b0, e_sn, q_ev.seq);
                    end else if (q_ev.ack) begin
                      pend_nxt = mk_hdr(1'b0, 1'b0, 1'b0, 1'b1, e_sn, rc_r);
                    end else begin
                      cl = 1'b1;
                    end
                  end
                  PH_SYN_RCVD, PH_OPEN: begin
                    if (!in_win) begin
                      if (ph == PH_SYN_RCVD) begin
                        pend_nxt = mk_hdr(1'b1, 1'b1, 1'b0, 1'b0, e_si, ri_r);
                      end else begin
                        pend_nxt  = mk_hdr(1'b0, 1'b1, 1'b1, 1'b0, e_sn, rc_r);
                        idx_nxt   = '0;
                        state_nxt = ST_EACK_RD;
                      end
                    end else if (q_ev.syn || !q_ev.ack) begin
                      cl = 1'b1;
                    end else if (ak_s >= sn_s) begin
                      cl = 1'b1;
                    end else if (ak_s < su_s - 18'sd1 - w2_s) begin
                      cl = 1'b1;
                    end else if (ph == PH_SYN_RCVD && q_ev.ackno != e_si) begin
                      cl = 1'b1;
                    end else begin
                      ph   = PH_OPEN;
                      e_su = q_ev.ackno + 16'd1;
                      if (!q_ev.eak && q_ev.pay) begin
                        idx_nxt = '0;
                        if ({1'b0, rc_r} + 17'd1 == {1'b0, q_ev.seq}) begin
                          rc_nxt    = q_ev.seq;
                          state_nxt = ST_FLUSH_RD;
                        end else begin
                          v_nxt     = q_ev.seq;
                          found_nxt = 1'b0;
                          pend_nxt  = mk_hdr(1'b0, 1'b1, 1'b1, 1'b0, e_sn, rc_r);
                          state_nxt = ST_ADD_RD;
                        end
                        if (!q_ev.room) begin
                          cl = 1'b1;
                        end else begin
                          dl = 1'b1;
                        end
                      end
                    end
                  end
                  default: begin
                    cl = 1'b1;
                  end
                endcase
              end
            end
            OP_CONNECT: begin
              if (phase_r == PH_OPEN) begin
                rf = 1'b1;
              end else begin
                e_si = ACTIVE_ISS;
                e_sn = ACTIVE_ISS + 16'd1;
                e_su = ACTIVE_ISS;
                ph   = PH_SYN_SENT;
                pend_nxt = mk_hdr(1'b1, 1'b0, 1'b0, 1'b0, ACTIVE_ISS, 16'd0);
              end
            end
            OP_SEND: begin
              if (phase_r != PH_OPEN || {1'b0, sn_r} >= {1'b0, su_r} + 17'(window)) begin
                rf = 1'b1;
              end else begin
                pend_nxt = mk_hdr(1'b0, 1'b1, 1'b0, 1'b0, sn_r, rc_r);
                e_sn = sn_r + 16'd1;
              end
            end
            OP_CLOSE: begin
              if (phase_r != PH_CLOSE_WAIT) begin
                pend_nxt = mk_hdr(1'b0, 1'b0, 1'b0, 1'b1, sn_r, rc_r);
                cl = 1'b1;
              end
            end
            default: begin
              rf = 1'b0;
            end
          endcase
          if (cl) begin
            ph = PH_CLOSE_WAIT;
          end
          phase_nxt   = ph;
          si_nxt      = e_si;
          sn_nxt      = e_sn;
          su_nxt      = e_su;
          deliver_nxt = dl;
          closed_nxt  = cl;
          refused_nxt = rf;
        end
      end
      // find the first free or matching slot, drop older copies of the number
      ST_ADD_RD: begin
        if (idx_in) begin
          rd_en     = 1'b1;
          state_nxt = ST_ADD_CHK;
        end else begin
          if (found_r) begin
            wr_en = 1'b1;
            occ_nxt[slot_r] = 1'b1;
          end
          idx_nxt   = '0;
          state_nxt = ST_EACK_RD;
        end
      end
      ST_ADD_CHK: begin
        if (hit) begin
          occ_nxt[idx_a] = 1'b0;
        end
        if ((hit || empty) && !found_r) begin
          slot_nxt  = idx_a;
          found_nxt = 1'b1;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = ST_ADD_RD;
      end
      // advance the receive number while the next one sits in the table
      ST_FLUSH_RD: begin
        if (idx_in) begin
          rd_en     = 1'b1;
          state_nxt = ST_FLUSH_CHK;
        end else begin
          pend_nxt  = mk_hdr(1'b0, 1'b1, 1'b0, 1'b0, sn_r, rc_r);
          state_nxt = ST_END;
        end
      end
      ST_FLUSH_CHK: begin
        if (occ_r[idx_a] && ({1'b0, rd_data} == {1'b0, rc_r} + 17'd1)) begin
          occ_nxt[idx_a] = 1'b0;
          rc_nxt  = rc_r + 16'd1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
        state_nxt = ST_FLUSH_RD;
      end
      ST_EACK_RD: begin
        if (idx_in) begin
          rd_en     = 1'b1;
          state_nxt = ST_EACK_CHK;
        end else begin
          state_nxt = ST_END;
        end
      end
      // hold one item back so the final one can carry last
      ST_EACK_CHK: begin
        if (occ_r[idx_a]) begin
          if (out_free) begin
            push           = 1'b1;
            pend_nxt       = '0;
            pend_nxt.kind  = KIND_ENTRY;
            pend_nxt.seq   = rd_data;
            idx_nxt        = idx_r + CW'(1);
            state_nxt      = ST_EACK_RD;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_EACK_RD;
        end
      end
      ST_END: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    if (push) begin
      out_valid_nxt      = 1'b1;
      res_nxt.item       = pend_r;
      res_nxt.deliver    = deliver_r;
      res_nxt.conn_state = phase_r;
      res_nxt.closed_now = closed_r;
      res_nxt.refused    = refused_r;
      res_nxt.last       = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_CLOSED;
      sn_r        <= '0;
      su_r        <= '0;
      si_r        <= '0;
      rc_r        <= '0;
      ri_r        <= '0;
      occ_r       <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      sn_r        <= sn_nxt;
      su_r        <= su_nxt;
      si_r        <= si_nxt;
      rc_r        <= rc_nxt;
      ri_r        <= ri_nxt;
      occ_r       <= occ_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r    <= slot_nxt;
    v_r       <= v_nxt;
    pend_r    <= pend_nxt;
    deliver_r <= deliver_nxt;
    closed_r  <= closed_nxt;
    refused_r <= refused_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

[sv/reliable_datagram_connection_fsm_unit.sv]
// Connection control for a reliable-datagram link: each input transfer is one event
// (received segment header, connect, send, close) and produces one or more result
// transfers, the final one marked by out_tlast. Events queue in a two-entry buffer
// ahead of the sequencer, so up to two more events are taken in during a table scan
// before in_tready drops. With N = min(2*window, TABLE_DEPTH), an EACK adds a scan
// of N table entries; an out-of-order insert adds its own scan of N entries ahead of
// that EACK scan; an in-order flush restarts its scan for each table entry it retires
// and ends with a final full pass. The sequencer waits while the result side holds
// off. Each scan reads the out-of-order table one entry at a time, a read state then
// a check state per entry. The table needs no clearing pass: each slot has an
// occupied flag cleared by reset.
module reliable_datagram_connection_fsm_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // mode
  // syn, ack, eak, rst, seq[15:0], ackno[15:0], has_payload, rx_room, pad
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  // syn, ack, eak, rst, seq[15:0], ackno[15:0], deliver, conn_state[2:0],
  // closed_now, refused, pad
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rdc_pkg::*;

  logic [3:0] window_r, window_nxt;
  logic       q_valid, q_pop;
  event_t     q_ev;
  result_t    res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_WINDOW) ? {28'd0, window_r} : 32'd0;

  always_comb begin
    window_nxt = window_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_WINDOW) begin
      window_nxt = cfg_pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  rdc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ev      (q_ev),
    .q_pop     (q_pop)
  );

  rdc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .window    (window_r),
    .q_valid   (q_valid),
    .q_ev      (q_ev),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  assign out_tuser = res.item.kind;
  assign out_tlast = res.last;
  assign out_tdata = {6'd0, res.refused, res.closed_now, res.conn_state, res.deliver,
                      res.item.ackno, res.item.seq, res.item.rst, res.item.eak,
                      res.item.ack, res.item.syn};

  a_deliver_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.deliver |-> res.conn_state == PH_OPEN)
    else $error("payload delivered outside open phase");

  a_closed_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.closed_now |-> res.conn_state == PH_CLOSE_WAIT)
    else $error("close path without close-wait phase");

  a_refused_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.refused |-> res.last && res.item.kind == KIND_STATUS)
    else $error("refused event produced more than a status result");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("event taken while previous event still in progress");

endmodule

[bench/reliable_datagram_connection_fsm_unit_tb.sv]
`timescale 1ns / 1ps

module reliable_datagram_connection_fsm_unit_tb;
  import rdc_pkg::*;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic [47:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  reliable_datagram_connection_fsm_unit #(.TABLE_DEPTH(DEPTH)) dut (.*);

  always #5 clk = ~clk;

  // connection mirror
  int     win_segs;
  phase_t conn_ph;
  int     snd_nxt, snd_una, snd_iss, rcv_cur, rcv_irs;
  int     ooo_tbl[DEPTH];
  item_t  hdr_list[$];
  result_t predicted_results[$];

  bit failed = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  result_t got;

  function automatic void push_hdr(kind_t k, bit s, bit a, bit e, bit r, int sq, int ak);
    item_t it;
    it.kind = k; it.syn = s; it.ack = a; it.eak = e; it.rst = r;
    it.seq = sq[15:0]; it.ackno = ak[15:0];
    hdr_list.push_back(it);
  endfunction

  function automatic int scan_len();
    return (win_segs * 2 > DEPTH) ? DEPTH : win_segs * 2;
  endfunction

  function automatic void emit_eack();
    push_hdr(KIND_HEADER, 0, 1, 1, 0, snd_nxt, rcv_cur);
    for (int i = 0; i < scan_len(); i++)
      if (ooo_tbl[i] != 0) push_hdr(KIND_ENTRY, 0, 0, 0, 0, ooo_tbl[i], 0);
  endfunction

  function automatic void park_seq(int v);
    for (int i = 0; i < scan_len(); i++)
      if (ooo_tbl[i] == v) ooo_tbl[i] = 0;
    for (int i = 0; i < scan_len(); i++)
      if (ooo_tbl[i] == 0) begin
        ooo_tbl[i] = v;
        return;
      end
  endfunction

  function automatic void retire_in_order();
    bit found = 1'b1;
    while (found) begin
      found = 1'b0;
      for (int i = 0; i < scan_len(); i++)
        if (ooo_tbl[i] == rcv_cur + 1) begin
          ooo_tbl[i] = 0;
          rcv_cur = (rcv_cur + 1) & 16'hFFFF;
          found = 1'b1;
          break;
        end
    end
  endfunction

  // returns 1 when the segment forces the connection closed
  function automatic bit take_segment(event_t e, output bit dlv);
    int w2 = win_segs * 2;
    int sq = e.seq;
    int ak = e.ackno;
    dlv = 1'b0;
    if (conn_ph == PH_CLOSED) begin
      snd_iss = PASSIVE_ISS; snd_nxt = PASSIVE_ISS + 1; snd_una = PASSIVE_ISS;
      conn_ph = PH_LISTEN;
    end
    if (e.rst) return 1'b1;
    case (conn_ph)
      PH_LISTEN: begin
        if (e.ack) begin
          push_hdr(KIND_HEADER, 0, 0, 0, 1, snd_nxt, rcv_cur);
          return 1'b1;
        end
        if (e.syn) begin
          rcv_cur = sq; rcv_irs = sq; conn_ph = PH_SYN_RCVD;
          push_hdr(KIND_HEADER, 1, 1, 0, 0, snd_iss, rcv_irs);
          return 1'b0;
        end
        return 1'b1;
      end
      PH_SYN_SENT: begin
        if (e.syn && e.ack) begin
          rcv_cur = sq; rcv_irs = sq;
          snd_una = (ak + 1) & 16'hFFFF;
          conn_ph = PH_OPEN;
          push_hdr(KIND_HEADER, 0, 1, 0, 0, snd_nxt, rcv_cur);
          return 1'b0;
        end
        if (e.ack) begin
          push_hdr(KIND_HEADER, 0, 0, 0, 1, snd_nxt, rcv_cur);
          return 1'b0;
        end
        return 1'b1;
      end
      PH_SYN_RCVD, PH_OPEN: begin
        if (!(rcv_cur < sq && sq <= rcv_cur + w2)) begin
          if (conn_ph == PH_SYN_RCVD) push_hdr(KIND_HEADER, 1, 1, 0, 0, snd_iss, rcv_irs);
          else emit_eack();
          return 1'b0;
        end
        if (e.syn || !e.ack) return 1'b1;
        if (ak >= snd_nxt) return 1'b1;
        if (ak < snd_una - 1 - w2) return 1'b1;
        if (conn_ph == PH_SYN_RCVD) begin
          if (ak != snd_iss) return 1'b1;
          conn_ph = PH_OPEN;
        end
        snd_una = (ak + 1) & 16'hFFFF;
        if (e.eak || !e.pay) return 1'b0;
        if (rcv_cur + 1 == sq) begin
          rcv_cur = sq;
          retire_in_order();
          push_hdr(KIND_HEADER, 0, 1, 0, 0, snd_nxt, rcv_cur);
        end else begin
          park_seq(sq);
          emit_eack();
        end
        if (!e.room) return 1'b1;
        dlv = 1'b1;
        return 1'b0;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic void predict_event(event_t e);
    bit dlv = 1'b0;
    bit closed = 1'b0;
    bit refused = 1'b0;
    result_t r;
    hdr_list.delete();
    case (e.op)
      OP_SEGMENT: closed = take_segment(e, dlv);
      OP_CONNECT: begin
        if (conn_ph == PH_OPEN) refused = 1'b1;
        else begin
          snd_iss = ACTIVE_ISS; snd_nxt = ACTIVE_ISS + 1; snd_una = ACTIVE_ISS;
          conn_ph = PH_SYN_SENT;
          push_hdr(KIND_HEADER, 1, 0, 0, 0, snd_iss, 0);
        end
      end
      OP_SEND: begin
        if (conn_ph != PH_OPEN || snd_nxt >= snd_una + win_segs) refused = 1'b1;
        else begin
          push_hdr(KIND_HEADER, 0, 1, 0, 0, snd_nxt, rcv_cur);
          snd_nxt = (snd_nxt + 1) & 16'hFFFF;
        end
      end
      default: begin
        if (conn_ph != PH_CLOSE_WAIT) begin
          push_hdr(KIND_HEADER, 0, 0, 0, 1, snd_nxt, rcv_cur);
          closed = 1'b1;
        end
      end
    endcase
    if (closed) conn_ph = PH_CLOSE_WAIT;
    if (hdr_list.size() == 0) push_hdr(KIND_STATUS, 0, 0, 0, 0, 0, 0);
    foreach (hdr_list[k]) begin
      r.item = hdr_list[k];
      r.deliver = dlv;
      r.conn_state = conn_ph;
      r.closed_now = closed;
      r.refused = refused;
      r.last = (k == hdr_list.size() - 1);
      predicted_results.push_back(r);
    end
  endfunction

  function automatic event_t mk_event(op_t op, bit s, bit a, bit e, bit r, int sq, int ak,
                                     bit pay, bit room);
    event_t ev;
    ev.op = op; ev.syn = s; ev.ack = a; ev.eak = e; ev.rst = r;
    ev.seq = sq[15:0]; ev.ackno = ak[15:0]; ev.pay = pay; ev.room = room;
    return ev;
  endfunction

  // mostly well-formed traffic for the current phase, some noise
  function automatic event_t rand_event();
    event_t ev;
    int r = $urandom_range(99);
    int r2 = $urandom_range(99);
    int w2 = win_segs * 2;
    int lo;
    ev = mk_event(op_t'($urandom_range(3)), 1'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), $urandom, $urandom, 1'($urandom), 1'($urandom));
    if (r < 8) return ev;
    ev.op = OP_SEGMENT;
    case (conn_ph)
      PH_SYN_SENT: begin
        if (r2 < 75) ev = mk_event(OP_SEGMENT, 1, 1, 0, 0, $urandom_range(0, 60000),
                                   (r2 < 60) ? snd_iss : $urandom_range(90, 120), 0, 1);
      end
      PH_SYN_RCVD: ev = mk_event(OP_SEGMENT, 0, 1, 0, 0, rcv_cur + $urandom_range(1, w2),
                                 snd_iss, 1'($urandom), 1);
      PH_OPEN: begin
        if (r2 < 25) ev.op = OP_SEND;
        else if (r2 < 29) ev.op = OP_CLOSE;
        else if (r2 < 32) ev.op = OP_CONNECT;
        else begin
          lo = (snd_una > 0) ? snd_una - 1 : 0;
          ev = mk_event(OP_SEGMENT, 0, 1, ($urandom_range(99) < 5), 0,
                        ($urandom_range(99) < 10) ? rcv_cur - $urandom_range(0, 3)
                                                  : rcv_cur + $urandom_range(1, w2),
                        (snd_nxt - 1 >= lo) ? $urandom_range(lo, snd_nxt - 1) : lo,
                        ($urandom_range(99) < 85), ($urandom_range(99) < 95));
        end
      end
      default: if (r2 < 70) ev.op = OP_CONNECT;
    endcase
    return ev;
  endfunction

  task automatic send_event(event_t ev);
    in_tvalid <= 1'b1;
    in_tuser  <= ev.op;
    in_tdata  <= {2'b00, ev.room, ev.pay, ev.ackno, ev.seq, ev.rst, ev.eak, ev.ack, ev.syn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_event(ev);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_window(int v);
    drain_results();
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= '0; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    win_segs = v;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic test_directed();
    send_event(mk_event(OP_SEGMENT, 1, 0, 0, 0, 1000, 0, 0, 1));
    send_event(mk_event(OP_SEGMENT, 0, 1, 0, 0, 1000, 200, 0, 1));
    send_event(mk_event(OP_SEGMENT, 0, 1, 0, 0, 1001, 200, 0, 1));
    repeat (4) send_event(mk_event(OP_SEND, 0, 0, 0, 0, 0, 0, 0, 0));
    send_event(mk_event(OP_SEGMENT, 0, 1, 0, 0, 1002, 203, 1, 1));
    send_event(mk_event(OP_SEGMENT, 0, 1, 0, 0, 1003, 203, 1, 1));
    send_event(mk_event(OP_SEGMENT, 0, 1, 0, 0, 1001, 203, 1, 1));
    send_event(mk_event(OP_SEGMENT, 0, 1, 1, 0, 1004, 203, 1, 1));
    send_event(mk_event(OP_SEGMENT, 0, 1, 0, 0, 1004, 203, 1, 0));
    send_event(mk_event(OP_SEGMENT, 1, 1, 1, 0, 16'hFFFF, 16'hFFFF, 1, 1));
    send_event(mk_event(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_event(mk_event(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_event(mk_event(OP_SEGMENT, 0, 1, 0, 0, 5, 5, 0, 1));
    send_event(mk_event(OP_SEGMENT, 0, 0, 0, 0, 5, 5, 0, 1));
    send_event(mk_event(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_event(mk_event(OP_SEGMENT, 1, 1, 0, 0, 16'hFFFF, 16'hFFFF, 0, 1));
    send_event(mk_event(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_event(mk_event(OP_SEGMENT, 0, 1, 0, 0, 0, 0, 1, 1));
    send_event(mk_event(OP_SEND, 0, 0, 0, 0, 0, 0, 0, 0));
    send_event(mk_event(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_event(mk_event(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_event(mk_event(OP_SEGMENT, 1, 1, 0, 0, 300, 100, 0, 1));
    send_event(mk_event(OP_SEGMENT, 0, 0, 0, 1, 301, 100, 1, 1));
  endtask

  task automatic test_random(int n, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) send_event(rand_event());
  endtask

  // hold the result side off while events keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    repeat (30) send_event(rand_event());
  endtask

  always @(posedge clk) begin
    if (hold_go && hold_left == 0) begin
      hold_left <= 400;
      hold_go <= 1'b0;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string nm, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", nm, want, seen);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_results.size() == 0) begin
        $error("result transfer with nothing pending");
        failed = 1'b1;
      end else begin
        got = predicted_results.pop_front();
        check_field("kind", got.item.kind, out_tuser);
        check_field("syn_out", got.item.syn, out_tdata[0]);
        check_field("ack_out", got.item.ack, out_tdata[1]);
        check_field("eak_out", got.item.eak, out_tdata[2]);
        check_field("rst_out", got.item.rst, out_tdata[3]);
        check_field("seq_out", got.item.seq, out_tdata[19:4]);
        check_field("ackno_out", got.item.ackno, out_tdata[35:20]);
        check_field("deliver", got.deliver, out_tdata[36]);
        check_field("conn_state", got.conn_state, out_tdata[39:37]);
        check_field("closed_now", got.closed_now, out_tdata[40]);
        check_field("refused", got.refused, out_tdata[41]);
        check_field("last", got.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    win_segs = WINDOW_RESET;
    conn_ph = PH_CLOSED;
    snd_nxt = 0; snd_una = 0; snd_iss = 0; rcv_cur = 0; rcv_irs = 0;
    foreach (ooo_tbl[i]) ooo_tbl[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_window(1);
    test_random(75, 36, 63);
    write_window(8);
    test_random(75, 63, 36);
    test_backpressure();
    write_window($urandom_range(2, 7));
    test_random(75, 0, 0);
    drain_results();
    if (!failed) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
